// ===== sv/blpa_pkg.sv =====
// blpa_pkg: shared constants and types for the button long-press / auto-repeat block
// no dependencies; imported by button_long_press_autorepeat_top
package blpa_pkg;

  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 8;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int MS_W         = 16;
  localparam int CD_W         = 18;

  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [MS_W-1:0] REPEAT_RST     = 16'd500;
  localparam logic [MS_W-1:0] ACCEL_RST      = 16'd10;
  localparam logic [MS_W-1:0] COUNT_MAX      = 16'hffff;

  typedef enum logic [1:0] {
    REG_INVERT     = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_REPEAT     = 2'd2,
    REG_ACCEL      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic in_long_press;
    logic held_now;
    logic long_press_event;
    logic release_event;
    logic press_event;
  } result_t;

endpackage

// ===== sv/button_long_press_autorepeat_top.sv =====
// button_long_press_autorepeat_top: long-press detection with accelerating auto-repeat
// depends on blpa_pkg
//
//  channel | dir | handshake            | contents
//  in_     | in  | tvalid/tready        | one tick: raw level and elapsed ms
//  out_    | out | tvalid/tready        | one result item per tick: event flags
//  cfg_    | in  | apb, pready always 1 | four registers at 0x0, 0x4, 0x8, 0xc
//
// one item per cycle sustained while out_ is not stalled; an accepted item reaches out_tvalid
// through the input register at the accepting edge, then the state update and result register
// the state loop holds a compare, two subtracts and one 16x16 multiply for the
// repeat interval, all between the two registers
// rst_n is synchronous active low; it restores register defaults and the state
// a stall on out_ backs up into the input register, then drops in_tready
module button_long_press_autorepeat_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [0] raw_level, [16:1] elapsed_ms, [23:17] zero
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [blpa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: [0] press_event, [1] release_event, [2] long_press_event,
  //            [3] held_now, [4] in_long_press, [7:5] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [blpa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [blpa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [blpa_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [blpa_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import blpa_pkg::*;

  // configuration registers
  logic            invert_r;
  logic [MS_W-1:0] long_press_r;
  logic [MS_W-1:0] repeat_r;
  logic [MS_W-1:0] accel_r;

  // tick state
  logic                   was_down_r;
  logic                   long_active_r;
  logic signed [CD_W-1:0] countdown_r;
  logic [MS_W-1:0]        repeat_count_r;

  // pipeline registers
  logic            s1_valid_r;
  logic            s1_level_r;
  logic [MS_W-1:0] s1_elapsed_r;
  logic            out_valid_r;
  result_t         res_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     advance;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_INVERT:     cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, invert_r};
      REG_LONG_PRESS: cfg_prdata = {{(CFG_DATA_W-MS_W){1'b0}}, long_press_r};
      REG_REPEAT:     cfg_prdata = {{(CFG_DATA_W-MS_W){1'b0}}, repeat_r};
      REG_ACCEL:      cfg_prdata = {{(CFG_DATA_W-MS_W){1'b0}}, accel_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r     <= 1'b0;
      long_press_r <= LONG_PRESS_RST;
      repeat_r     <= REPEAT_RST;
      accel_r      <= ACCEL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INVERT:     invert_r     <= cfg_pwdata[0];
        REG_LONG_PRESS: long_press_r <= cfg_pwdata[MS_W-1:0];
        REG_REPEAT:     repeat_r     <= cfg_pwdata[MS_W-1:0];
        REG_ACCEL:      accel_r      <= cfg_pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // the result register frees up when empty or being taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  // state update for the item in the input register
  logic                   level;
  logic signed [CD_W-1:0] cd_diff;
  logic                   fire;
  logic [MS_W-1:0]        count_inc;
  logic [2*MS_W-1:0]      accel_prod;
  logic [MS_W-1:0]        interval;
  logic                   was_down_nxt;
  logic                   long_active_nxt;
  logic signed [CD_W-1:0] countdown_nxt;
  logic [MS_W-1:0]        repeat_count_nxt;
  result_t                res_nxt;

  always_comb begin
    level     = s1_level_r ^ invert_r;
    cd_diff   = countdown_r - $signed({2'b00, s1_elapsed_r});
    fire      = 1'b0;
    count_inc = (repeat_count_r != COUNT_MAX) ? repeat_count_r + 1'b1 : repeat_count_r;
    // interval uses the count after this repeat; below 1 clamps to 1
    accel_prod = count_inc * accel_r;
    interval   = (accel_prod < {{MS_W{1'b0}}, repeat_r})
                 ? repeat_r - accel_prod[MS_W-1:0] : {{(MS_W-1){1'b0}}, 1'b1};

    was_down_nxt     = level;
    long_active_nxt  = long_active_r;
    countdown_nxt    = countdown_r;
    repeat_count_nxt = repeat_count_r;
    res_nxt          = '0;

    if (level && !was_down_r) begin
      // press edge: countdown left as is on this tick
      res_nxt.press_event = 1'b1;
      repeat_count_nxt    = '0;
    end else if (!level && was_down_r) begin
      res_nxt.release_event = !long_active_r;
      long_active_nxt       = 1'b0;
      countdown_nxt         = $signed({2'b00, long_press_r});
    end else if (level) begin
      // countdown only runs while positive
      if (countdown_r > 0) begin
        countdown_nxt = cd_diff;
        fire          = (cd_diff <= 0);
      end
      if (fire) begin
        res_nxt.long_press_event = !long_active_r;
        long_active_nxt          = 1'b1;
        res_nxt.press_event      = 1'b1;
        repeat_count_nxt         = count_inc;
        countdown_nxt            = $signed({2'b00, interval});
      end
    end

    res_nxt.held_now      = level;
    res_nxt.in_long_press = long_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      was_down_r     <= 1'b0;
      long_active_r  <= 1'b0;
      countdown_r    <= $signed({2'b00, LONG_PRESS_RST});
      repeat_count_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          was_down_r     <= was_down_nxt;
          long_active_r  <= long_active_nxt;
          countdown_r    <= countdown_nxt;
          repeat_count_r <= repeat_count_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r   <= in_tdata[0];
      s1_elapsed_r <= in_tdata[MS_W:1];
    end
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, res_r};

`ifndef SYNTHESIS
  a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res_r.press_event && res_r.release_event))
    else $error("press and release reported in one item");
  a_long_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.long_press_event |-> res_r.in_long_press && res_r.press_event)
    else $error("long press without press or long state");
  a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.release_event |-> !res_r.held_now && !res_r.in_long_press)
    else $error("release reported while held");
  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_r.held_now == was_down_r && res_r.in_long_press == long_active_r)
    else $error("result register out of step with state");
`endif

endmodule
